>>> rtl/btn_dbnc_pkg.sv
// ----------------------------------------------------------------------------
// btn_dbnc_pkg
// Shared types and constants for the button debouncer with auto-repeat.
// ----------------------------------------------------------------------------
package btn_dbnc_pkg;

	localparam int unsigned PIN_W  = 8;
	localparam int unsigned TICK_W = 16;

	// item kinds
	localparam logic ACT_TICK = 1'b0;
	localparam logic ACT_POLL = 1'b1;

	// configuration register indexes
	localparam logic REG_REPEAT_DELAY    = 1'b0;
	localparam logic REG_REPEAT_INTERVAL = 1'b1;

	localparam logic [TICK_W-1:0] DEBOUNCE_TICKS   = TICK_W'(5);
	localparam logic [TICK_W-1:0] SETTLE_TICKS     = TICK_W'(3);
	localparam logic [TICK_W-1:0] DEFAULT_DELAY    = TICK_W'(100);
	localparam logic [TICK_W-1:0] DEFAULT_INTERVAL = TICK_W'(20);

	typedef struct packed {
		logic             action;
		logic [PIN_W-1:0] pin_number;
		logic             pin_level;
	} item_t;

	typedef struct packed {
		logic push_event;
		logic repeat_event;
	} result_t;

	// state summary from the press machine, for checks in the top level
	typedef struct packed {
		logic locked;     // a nonzero pin is locked
		logic held;       // phase is settle, wait or repeat
		logic repeating;  // phase is repeat
	} status_t;

endpackage

>>> rtl/btn_dbnc_if.sv
// ----------------------------------------------------------------------------
// btn_dbnc_if
// Valid/ready channels for pin requests and event results.
// ----------------------------------------------------------------------------
interface btn_dbnc_item_if import btn_dbnc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             action;
	logic [PIN_W-1:0] pin_number;
	logic             pin_level;

	modport source (output valid, output action, output pin_number, output pin_level,
		input ready);
	modport sink (input valid, input action, input pin_number, input pin_level,
		output ready);
endinterface

interface btn_dbnc_result_if;
	logic valid;
	logic ready;
	logic push_event;
	logic repeat_event;

	modport source (output valid, output push_event, output repeat_event, input ready);
	modport sink (input valid, input push_event, input repeat_event, output ready);
endinterface

>>> rtl/btn_dbnc_fsm.sv
// ----------------------------------------------------------------------------
// btn_dbnc_fsm
// Press machine: phase, tick countdown and locked pin, one request per step.
// ----------------------------------------------------------------------------
module btn_dbnc_fsm import btn_dbnc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  item_t             item,
	input  logic [TICK_W-1:0] repeat_delay,
	input  logic [TICK_W-1:0] repeat_interval,
	output result_t           result,
	output status_t           status
);

	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_DEBOUNCE = 3'd1,
		PH_SETTLE   = 3'd2,
		PH_WAIT     = 3'd3,
		PH_REPEAT   = 3'd4
	} phase_t;

	phase_t            phase_q, phase_n;
	logic [TICK_W-1:0] count_q, count_n;
	logic [PIN_W-1:0]  lock_q, lock_n;
	logic              pressed, expired, other_pin;
	logic [TICK_W-1:0] delay_ld, interval_ld;

	assign pressed     = !item.pin_level;
	assign expired     = (count_q == '0);
	assign other_pin   = (lock_q != '0) && (lock_q != item.pin_number);
	assign delay_ld    = (repeat_delay != '0) ? repeat_delay : DEFAULT_DELAY;
	assign interval_ld = (repeat_interval != '0) ? repeat_interval : DEFAULT_INTERVAL;

	always_comb begin
		phase_n = phase_q;
		count_n = count_q;
		lock_n  = lock_q;
		result  = '0;
		if (item.action == ACT_TICK) begin
			if (!expired)
				count_n = count_q - TICK_W'(1);
		end else if (!other_pin) begin
			if (pressed && phase_q == PH_IDLE) begin
				phase_n = PH_DEBOUNCE;
				count_n = DEBOUNCE_TICKS;
			end else if (phase_q != PH_IDLE) begin
				if (pressed && phase_q == PH_DEBOUNCE && expired) begin
					phase_n = PH_SETTLE;
					count_n = SETTLE_TICKS;
					lock_n  = item.pin_number;
				end else if (!pressed && (phase_q == PH_SETTLE || phase_q == PH_WAIT)) begin
					result.push_event = 1'b1;
					phase_n = PH_IDLE;
					lock_n  = '0;
				end else if (pressed && phase_q == PH_SETTLE && expired) begin
					phase_n = PH_WAIT;
					count_n = delay_ld;
				end else if (pressed && phase_q == PH_WAIT && expired) begin
					phase_n = PH_REPEAT;
				end else if (pressed && phase_q == PH_REPEAT && expired) begin
					count_n = interval_ld;
					result.repeat_event = 1'b1;
				end
			end
			// release while repeating drops back to idle
			if (!pressed && phase_q == PH_REPEAT) begin
				phase_n = PH_IDLE;
				lock_n  = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			count_q <= '0;
			lock_q  <= '0;
		end else if (step) begin
			phase_q <= phase_n;
			count_q <= count_n;
			lock_q  <= lock_n;
		end
	end

	assign status.locked    = (lock_q != '0);
	assign status.held      = (phase_q == PH_SETTLE) || (phase_q == PH_WAIT)
		|| (phase_q == PH_REPEAT);
	assign status.repeating = (phase_q == PH_REPEAT);

endmodule

>>> rtl/button_debounce_auto_repeat.sv
// ----------------------------------------------------------------------------
// button_debounce_auto_repeat
// Button debouncer with auto-repeat, valid/ready request and result channels.
// ----------------------------------------------------------------------------
// Each request is a timer tick or a poll of one button pin (active low). The
// block takes one request per clock and returns exactly one result per
// request: the request lands in an input register, the press machine's
// next-state logic works on it there and its events are caught in the
// result register. A stall on the result side holds both stages; the input
// side keeps accepting as long as the input register can move on. Ticks only
// count down; polls drive the phases idle, debounce (5 ticks), settle (3
// ticks), wait (repeat_delay ticks) and repeat (one repeat_event each
// repeat_interval ticks). A zero register value selects 100 for the delay
// and 20 for the interval. Write the registers only while no request is in
// flight.
module button_debounce_auto_repeat import btn_dbnc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	btn_dbnc_item_if.sink     btn,
	btn_dbnc_result_if.source evt,
	input  logic              wr_en,
	input  logic              wr_index,
	input  logic [TICK_W-1:0] wr_data
);

	logic [TICK_W-1:0] delay_q, interval_q;
	logic              valid_s1, valid_s2;
	item_t             item_s1;
	result_t           res_s2, res_n;
	status_t           status;
	logic              advance, step, take;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q    <= DEFAULT_DELAY;
			interval_q <= DEFAULT_INTERVAL;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_REPEAT_DELAY:    delay_q    <= wr_data;
				REG_REPEAT_INTERVAL: interval_q <= wr_data;
				default:             ;
			endcase
		end
	end

	// result register frees up when empty or taken
	assign advance   = !valid_s2 || evt.ready;
	assign step      = valid_s1 && advance;
	assign btn.ready = !valid_s1 || advance;
	assign take      = btn.valid && btn.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take)
				valid_s1 <= 1'b1;
			else if (step)
				valid_s1 <= 1'b0;
			if (step)
				valid_s2 <= 1'b1;
			else if (evt.ready)
				valid_s2 <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.action     <= btn.action;
			item_s1.pin_number <= btn.pin_number;
			item_s1.pin_level  <= btn.pin_level;
		end
		if (step)
			res_s2 <= res_n;
	end

	btn_dbnc_fsm u_fsm (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (step),
		.item            (item_s1),
		.repeat_delay    (delay_q),
		.repeat_interval (interval_q),
		.result          (res_n),
		.status          (status)
	);

	assign evt.valid        = valid_s2;
	assign evt.push_event   = res_s2.push_event;
	assign evt.repeat_event = res_s2.repeat_event;

	// a single request never fires both events
	assert property (@(posedge clk) disable iff (!arst_n)
		evt.valid |-> !(evt.push_event && evt.repeat_event))
		else $error("push and repeat fired together");

	// ticks never produce an event
	assert property (@(posedge clk) disable iff (!arst_n)
		step && item_s1.action == ACT_TICK |=> !evt.push_event && !evt.repeat_event)
		else $error("event on a tick");

	// a lock exists only while the press is past debounce
	assert property (@(posedge clk) disable iff (!arst_n)
		status.locked |-> status.held)
		else $error("pin locked outside a held phase");

	// repeat events come only from the repeat phase
	assert property (@(posedge clk) disable iff (!arst_n)
		step && res_n.repeat_event |-> status.repeating)
		else $error("repeat event outside repeat phase");

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the button debouncer with auto-repeat against its own press-machine
// predictor. A directed table covers the corner cases, then random press
// gestures run under several register settings. Both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;
	import btn_dbnc_pkg::*;

	// press machine phases, same codes as the block uses
	typedef enum logic [2:0] {
		ST_IDLE     = 3'd0,
		ST_DEBOUNCE = 3'd1,
		ST_SETTLE   = 3'd2,
		ST_WAIT     = 3'd3,
		ST_REPEAT   = 3'd4
	} press_phase_t;

	// one row of the directed table; fixed rows carry a typed-in result
	typedef struct packed {
		item_t   req;
		logic    fixed;
		result_t want;
	} stim_row_t;

	localparam result_t NO_EVENT   = '{1'b0, 1'b0};
	localparam result_t PUSH_EVENT = '{1'b1, 1'b0};

	localparam int unsigned NUM_SETTINGS     = 7;
	localparam int unsigned ITEMS_PER_PHASE  = 115;
	localparam int unsigned TAIL_CYCLES      = 8;
	localparam int unsigned RUN_LIMIT        = 4000000;

	// Directed part, run with the reset register values.
	// Pin 7: release at idle, release during debounce, other pin while locked,
	// push from settle. Pin 0: locks as "no pin", so pin 255 is not ignored;
	// settle to wait, then push from wait. Tick rows carry noise in pin fields.
	localparam stim_row_t DIRECTED_ROWS [25] = '{
		'{'{ACT_TICK, 8'd0,   1'b1}, 1'b1, NO_EVENT},   // tick at zero count
		'{'{ACT_POLL, 8'd7,   1'b1}, 1'b1, NO_EVENT},   // release at idle
		'{'{ACT_POLL, 8'd7,   1'b0}, 1'b1, NO_EVENT},   // press -> debounce
		'{'{ACT_POLL, 8'd7,   1'b1}, 1'b0, NO_EVENT},   // release in debounce
		'{'{ACT_TICK, 8'd255, 1'b0}, 1'b1, NO_EVENT},
		'{'{ACT_TICK, 8'd170, 1'b1}, 1'b1, NO_EVENT},
		'{'{ACT_TICK, 8'd85,  1'b0}, 1'b1, NO_EVENT},
		'{'{ACT_TICK, 8'd1,   1'b1}, 1'b1, NO_EVENT},
		'{'{ACT_TICK, 8'd128, 1'b0}, 1'b1, NO_EVENT},
		'{'{ACT_POLL, 8'd7,   1'b0}, 1'b0, NO_EVENT},   // -> settle, lock 7
		'{'{ACT_POLL, 8'd9,   1'b1}, 1'b0, NO_EVENT},   // other pin, ignored
		'{'{ACT_POLL, 8'd7,   1'b1}, 1'b1, PUSH_EVENT}, // release in settle
		'{'{ACT_POLL, 8'd0,   1'b0}, 1'b0, NO_EVENT},   // pin 0 -> debounce
		'{'{ACT_TICK, 8'd0,   1'b0}, 1'b1, NO_EVENT},
		'{'{ACT_TICK, 8'd255, 1'b1}, 1'b1, NO_EVENT},
		'{'{ACT_TICK, 8'd15,  1'b0}, 1'b1, NO_EVENT},
		'{'{ACT_TICK, 8'd240, 1'b1}, 1'b1, NO_EVENT},
		'{'{ACT_TICK, 8'd60,  1'b0}, 1'b1, NO_EVENT},
		'{'{ACT_POLL, 8'd0,   1'b0}, 1'b0, NO_EVENT},   // -> settle, lock 0
		'{'{ACT_POLL, 8'd255, 1'b0}, 1'b0, NO_EVENT},   // not ignored, not expired
		'{'{ACT_TICK, 8'd3,   1'b1}, 1'b1, NO_EVENT},
		'{'{ACT_TICK, 8'd204, 1'b0}, 1'b1, NO_EVENT},
		'{'{ACT_TICK, 8'd51,  1'b1}, 1'b1, NO_EVENT},
		'{'{ACT_POLL, 8'd255, 1'b0}, 1'b0, NO_EVENT},   // -> wait
		'{'{ACT_POLL, 8'd255, 1'b1}, 1'b0, NO_EVENT}    // release in wait
	};

	logic clk;
	logic arst_n;
	logic wr_en;
	logic wr_index;
	logic [TICK_W-1:0] wr_data;

	btn_dbnc_item_if   btn_if ();
	btn_dbnc_result_if evt_if ();

	button_debounce_auto_repeat DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.btn      (btn_if),
		.evt      (evt_if),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// predictor state and register copies
	press_phase_t      pm_phase;
	logic [TICK_W-1:0] pm_countdown;
	logic [PIN_W-1:0]  pm_locked_pin;
	logic [TICK_W-1:0] pm_delay;
	logic [TICK_W-1:0] pm_interval;

	result_t     pending_events [$];
	int unsigned fail_count = 0;
	int unsigned burst_left;
	int unsigned stall_mode = 0;
	int unsigned stall_cycles = 0;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Advance the press machine by one request and return its events.
	function automatic result_t advance_press_machine(item_t req);
		result_t ev;
		logic    pressed;
		logic    expired;
		ev = NO_EVENT;
		pressed = (req.pin_level == 1'b0);
		if (req.action == ACT_TICK) begin
			if (pm_countdown != '0)
				pm_countdown = pm_countdown - 1'b1;
		end else if (!(pm_locked_pin != '0 && pm_locked_pin != req.pin_number)) begin
			expired = (pm_countdown == '0);
			if (pressed && pm_phase == ST_IDLE) begin
				pm_phase = ST_DEBOUNCE;
				pm_countdown = DEBOUNCE_TICKS;
			end else if (pm_phase != ST_IDLE) begin
				if (pressed && pm_phase == ST_DEBOUNCE && expired) begin
					pm_phase = ST_SETTLE;
					pm_countdown = SETTLE_TICKS;
					pm_locked_pin = req.pin_number;
				end else if (!pressed && (pm_phase == ST_SETTLE || pm_phase == ST_WAIT)) begin
					ev.push_event = 1'b1;
					pm_phase = ST_IDLE;
					pm_locked_pin = '0;
				end else if (pressed && pm_phase == ST_SETTLE && expired) begin
					pm_phase = ST_WAIT;
					pm_countdown = (pm_delay != '0) ? pm_delay : DEFAULT_DELAY;
				end else if (pressed && pm_phase == ST_WAIT && expired) begin
					pm_phase = ST_REPEAT;
				end else if (pressed && pm_phase == ST_REPEAT && expired) begin
					pm_countdown = (pm_interval != '0) ? pm_interval : DEFAULT_INTERVAL;
					ev.repeat_event = 1'b1;
				end
			end
			// release while held at or past wait always drops back to idle
			if (pm_phase >= ST_WAIT && !pressed) begin
				pm_phase = ST_IDLE;
				pm_locked_pin = '0;
			end
		end
		return ev;
	endfunction

	// Offer one request, honoring the burst/gap pattern, and queue its result
	// once accepted. Called at a rising edge, returns at the accepting edge.
	task automatic send_request(item_t req, logic fixed, result_t want);
		int unsigned gap;
		result_t     predicted;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				btn_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		btn_if.valid      <= 1'b1;
		btn_if.action     <= req.action;
		btn_if.pin_number <= req.pin_number;
		btn_if.pin_level  <= req.pin_level;
		@(posedge clk);
		while (!btn_if.ready)
			@(posedge clk);
		predicted = advance_press_machine(req);
		pending_events.push_back(fixed ? want : predicted);
	endtask

	// Stop offering requests and wait for every queued result.
	task automatic drain_events();
		btn_if.valid <= 1'b0;
		while (pending_events.size() != 0)
			@(posedge clk);
	endtask

	// Write both registers, delay first and interval second; block is idle here.
	task automatic write_registers(logic [TICK_W-1:0] delay, logic [TICK_W-1:0] interval);
		wr_en    <= 1'b1;
		wr_index <= REG_REPEAT_DELAY;
		wr_data  <= delay;
		@(posedge clk);
		wr_index <= REG_REPEAT_INTERVAL;
		wr_data  <= interval;
		@(posedge clk);
		wr_en    <= 1'b0;
		pm_delay    = delay;
		pm_interval = interval;
	endtask

	// Result side stalls in a mode that is redrawn periodically:
	// always ready, coin flip, or mostly stalled.
	always @(posedge clk) begin
		stall_cycles++;
		if (stall_cycles % 97 == 0)
			stall_mode = $urandom_range(0, 2);
		case (stall_mode)
			0: evt_if.ready <= 1'b1;
			1: evt_if.ready <= 1'($urandom_range(0, 1));
			default: evt_if.ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// Result checker: compare each accepted result with the oldest expectation.
	always @(posedge clk) begin
		result_t exp_ev;
		if (arst_n && evt_if.valid && evt_if.ready) begin
			if (pending_events.size() == 0) begin
				$display("%0t: unexpected result push_event %b repeat_event %b",
					$time, evt_if.push_event, evt_if.repeat_event);
				fail_count++;
			end else begin
				exp_ev = pending_events.pop_front();
				if (evt_if.push_event !== exp_ev.push_event) begin
					$display("%0t: push_event expected %b actual %b",
						$time, exp_ev.push_event, evt_if.push_event);
					fail_count++;
				end
				if (evt_if.repeat_event !== exp_ev.repeat_event) begin
					$display("%0t: repeat_event expected %b actual %b",
						$time, exp_ev.repeat_event, evt_if.repeat_event);
					fail_count++;
				end
			end
		end
	end

	// Main sequence: reset, directed table, then random gestures per setting.
	initial begin
		item_t             req;
		logic [PIN_W-1:0]  cur_pin;
		logic [TICK_W-1:0] set_delay;
		logic [TICK_W-1:0] set_interval;
		int unsigned       roll;

		arst_n            <= 1'b0;
		wr_en             <= 1'b0;
		wr_index          <= REG_REPEAT_DELAY;
		wr_data           <= '0;
		btn_if.valid      <= 1'b0;
		btn_if.action     <= ACT_TICK;
		btn_if.pin_number <= '0;
		btn_if.pin_level  <= 1'b1;
		burst_left   = 0;
		pm_phase      = ST_IDLE;
		pm_countdown  = '0;
		pm_locked_pin = '0;
		pm_delay      = DEFAULT_DELAY;
		pm_interval   = DEFAULT_INTERVAL;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_ROWS[i])
			send_request(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].fixed, DIRECTED_ROWS[i].want);

		cur_pin = 8'd3;
		for (int p = 0; p < NUM_SETTINGS; p++) begin
			// settings: both zero (defaults), minimum, maximum, then short ones
			// that reach repeat often, and one fully random pair
			case (p)
				0: begin set_delay = '0;       set_interval = '0;       end
				1: begin set_delay = 16'd1;    set_interval = 16'd1;    end
				2: begin set_delay = 16'hFFFF; set_interval = 16'hFFFF; end
				3: begin set_delay = 16'd2;    set_interval = 16'd5;    end
				6: begin
					set_delay    = TICK_W'($urandom_range(0, 65535));
					set_interval = TICK_W'($urandom_range(0, 65535));
				end
				default: begin
					set_delay    = TICK_W'($urandom_range(1, 12));
					set_interval = TICK_W'($urandom_range(1, 6));
				end
			endcase
			drain_events();
			write_registers(set_delay, set_interval);

			// Gestures on a current pin that changes after each release: mostly ticks
			// and presses so the machine climbs through settle and wait; some releases and stray polls.
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				roll = $urandom_range(0, 99);
				req.action     = ACT_POLL;
				req.pin_number = cur_pin;
				req.pin_level  = 1'b0;
				if (roll < 55) begin
					req.action     = ACT_TICK;
					req.pin_number = PIN_W'($urandom);
					req.pin_level  = 1'($urandom);
				end else if (roll < 86) begin
					req.pin_level = 1'b0;
				end else if (roll < 91) begin
					req.pin_level = 1'b1;
					case ($urandom_range(0, 5))
						0: cur_pin = '0;
						1: cur_pin = '1;
						default: cur_pin = PIN_W'($urandom_range(1, 254));
					endcase
				end else begin
					req.pin_number = PIN_W'($urandom);
					req.pin_level  = 1'($urandom);
				end
				send_request(req, 1'b0, NO_EVENT);
			end
		end

		drain_events();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_events.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// watchdog
	initial begin
		#(RUN_LIMIT);
		$display("Some tests failed");
		$finish;
	end

endmodule
